FILE: hdl/cpu8_pkg.sv
// Shared types and constants for the 8-bit register and ALU execute stage.
// No dependencies; imported by the execute unit and the top level.
package cpu8_pkg;

   // Operation codes, dense alphabetical numbering.
   typedef enum logic [6:0] {
      OP_ADC = 7'd0,  OP_AHX = 7'd1,  OP_ALR = 7'd2,  OP_ANC = 7'd3,  OP_AND = 7'd4,
      OP_ARR = 7'd5,  OP_ASL = 7'd6,  OP_AXS = 7'd7,  OP_BCC = 7'd8,  OP_BCS = 7'd9,
      OP_BEQ = 7'd10, OP_BIT = 7'd11, OP_BMI = 7'd12, OP_BNE = 7'd13, OP_BPL = 7'd14,
      OP_BVC = 7'd15, OP_BVS = 7'd16, OP_CLC = 7'd17, OP_CLD = 7'd18, OP_CLI = 7'd19,
      OP_CLV = 7'd20, OP_CMP = 7'd21, OP_CPX = 7'd22, OP_CPY = 7'd23, OP_DCP = 7'd24,
      OP_DEC = 7'd25, OP_DEX = 7'd26, OP_DEY = 7'd27, OP_EOR = 7'd28, OP_HLT = 7'd29,
      OP_INC = 7'd30, OP_INX = 7'd31, OP_INY = 7'd32, OP_ISC = 7'd33, OP_LAS = 7'd34,
      OP_LAX = 7'd35, OP_LDA = 7'd36, OP_LDX = 7'd37, OP_LDY = 7'd38, OP_LSR = 7'd39,
      OP_LXA = 7'd40, OP_NOP = 7'd41, OP_ORA = 7'd42, OP_PHA = 7'd43, OP_PHP = 7'd44,
      OP_PLA = 7'd45, OP_PLP = 7'd46, OP_RLA = 7'd47, OP_ROL = 7'd48, OP_ROR = 7'd49,
      OP_RRA = 7'd50, OP_SAX = 7'd51, OP_SBC = 7'd52, OP_SEC = 7'd53, OP_SED = 7'd54,
      OP_SEI = 7'd55, OP_SHX = 7'd56, OP_SHY = 7'd57, OP_SLO = 7'd58, OP_SRE = 7'd59,
      OP_STA = 7'd60, OP_STX = 7'd61, OP_STY = 7'd62, OP_TAS = 7'd63, OP_TAX = 7'd64,
      OP_TAY = 7'd65, OP_TSX = 7'd66, OP_TXA = 7'd67, OP_TXS = 7'd68, OP_TYA = 7'd69,
      OP_XAA = 7'd70
   } kind_type;

   // Status bit positions.
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_B = 4;
   localparam int unsigned FLAG_U = 5;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   localparam logic [7:0] STACK_RESET  = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] idx_x;
      logic [7:0] idx_y;
      logic [7:0] sp;
      logic [7:0] status;
   } regs_type;

   typedef struct packed {
      logic       mem_write;
      logic [7:0] write_data;
      logic       stack_write;
      logic [7:0] stack_offset;
      logic       branch_taken;
      logic       halt_request;
   } side_type;

endpackage

FILE: hdl/cpu8_exec.sv
// Combinational execute unit: one operation applied to the register set.
// Depends on cpu8_pkg.
module cpu8_exec import cpu8_pkg::*; (
   input  regs_type   regs_cur,
   input  logic [6:0] kind,
   input  logic [7:0] operand,
   input  logic       accumulator_mode,
   input  logic [7:0] address_high,
   input  logic [7:0] pulled_byte,
   output regs_type   regs_nxt,
   output side_type   side
);

   function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
      logic [7:0] o;
      o         = st;
      o[FLAG_Z] = (v == 8'd0);
      o[FLAG_N] = v[7];
      return o;
   endfunction

   // Add with carry: returns {status, sum}.
   function automatic logic [15:0] add_c(input logic [7:0] st, input logic [7:0] l,
                                         input logic [7:0] rhs);
      logic [8:0] sum;
      logic [7:0] o;
      sum       = {1'b0, l} + {1'b0, rhs} + {8'd0, st[FLAG_C]};
      o         = st;
      o[FLAG_C] = sum[8];
      o[FLAG_V] = (sum[7] ^ l[7]) & (sum[7] ^ rhs[7]);
      o         = set_nz(o, sum[7:0]);
      return {o, sum[7:0]};
   endfunction

   function automatic logic [7:0] cmp8(input logic [7:0] st, input logic [7:0] r,
                                       input logic [7:0] mv);
      logic [7:0] o;
      logic [7:0] d;
      d         = r - mv;
      o         = st;
      o[FLAG_C] = (r >= mv);
      o[FLAG_Z] = (r == mv);
      o[FLAG_N] = d[7];
      return o;
   endfunction

   always_comb begin
      logic [7:0]  a, x, y, s, p, m, hi1, r, c;
      logic [15:0] ac;
      logic        shift_kind;
      a = regs_cur.acc;
      x = regs_cur.idx_x;
      y = regs_cur.idx_y;
      s = regs_cur.sp;
      p = regs_cur.status;
      m = accumulator_mode ? regs_cur.acc : operand;
      hi1 = address_high + 8'd1;
      r = 8'd0;
      c = 8'd0;
      ac = 16'd0;
      shift_kind = 1'b0;
      side = '0;
      case (kind_type'(kind))
         OP_ADC: begin ac = add_c(p, a, m); p = ac[15:8]; a = ac[7:0]; end
         OP_AHX: begin side.mem_write = 1'b1; side.write_data = a & x & hi1; end
         OP_ALR: begin
            a = a & m; p[FLAG_C] = a[0]; a = a >> 1; p = set_nz(p, a);
         end
         OP_ANC: begin a = a & m; p = set_nz(p, a); p[FLAG_C] = a[7]; end
         OP_AND: begin a = a & m; p = set_nz(p, a); end
         OP_ARR: begin
            a = a & m;
            a = {p[FLAG_C], a[7:1]};
            p = set_nz(p, a);
            p[FLAG_C] = a[6];
            p[FLAG_V] = a[6] ^ a[5];
         end
         OP_ASL: begin r = {m[6:0], 1'b0}; p[FLAG_C] = m[7]; shift_kind = 1'b1; end
         OP_AXS: begin
            c = a & x; r = c - m; p[FLAG_C] = (c >= m); p = set_nz(p, r); x = r;
         end
         OP_BCC: side.branch_taken = ~p[FLAG_C];
         OP_BCS: side.branch_taken = p[FLAG_C];
         OP_BEQ: side.branch_taken = p[FLAG_Z];
         OP_BIT: begin
            p[FLAG_Z] = ((a & m) == 8'd0); p[FLAG_V] = m[6]; p[FLAG_N] = m[7];
         end
         OP_BMI: side.branch_taken = p[FLAG_N];
         OP_BNE: side.branch_taken = ~p[FLAG_Z];
         OP_BPL: side.branch_taken = ~p[FLAG_N];
         OP_BVC: side.branch_taken = ~p[FLAG_V];
         OP_BVS: side.branch_taken = p[FLAG_V];
         OP_CLC: p[FLAG_C] = 1'b0;
         OP_CLD: p[FLAG_D] = 1'b0;
         OP_CLI: p[FLAG_I] = 1'b0;
         OP_CLV: p[FLAG_V] = 1'b0;
         OP_CMP: p = cmp8(p, a, m);
         OP_CPX: p = cmp8(p, x, m);
         OP_CPY: p = cmp8(p, y, m);
         OP_DCP: begin
            r = m - 8'd1; side.mem_write = 1'b1; side.write_data = r; p = cmp8(p, a, r);
         end
         OP_DEC: begin
            r = m - 8'd1; side.mem_write = 1'b1; side.write_data = r; p = set_nz(p, r);
         end
         OP_DEX: begin x = x - 8'd1; p = set_nz(p, x); end
         OP_DEY: begin y = y - 8'd1; p = set_nz(p, y); end
         OP_EOR: begin a = a ^ m; p = set_nz(p, a); end
         OP_HLT: side.halt_request = 1'b1;
         OP_INC: begin
            r = m + 8'd1; side.mem_write = 1'b1; side.write_data = r; p = set_nz(p, r);
         end
         OP_INX: begin x = x + 8'd1; p = set_nz(p, x); end
         OP_INY: begin y = y + 8'd1; p = set_nz(p, y); end
         OP_ISC: begin
            r = m + 8'd1; side.mem_write = 1'b1; side.write_data = r;
            ac = add_c(p, a, ~r); p = ac[15:8]; a = ac[7:0];
         end
         OP_LAS: begin r = m & s; a = r; x = r; s = r; p = set_nz(p, r); end
         OP_LAX: begin a = m; x = m; p = set_nz(p, m); end
         OP_LDA: begin a = m; p = set_nz(p, m); end
         OP_LDX: begin x = m; p = set_nz(p, m); end
         OP_LDY: begin y = m; p = set_nz(p, m); end
         OP_LSR: begin r = {1'b0, m[7:1]}; p[FLAG_C] = m[0]; shift_kind = 1'b1; end
         OP_LXA: begin a = a & m; x = a; p = set_nz(p, a); end
         OP_ORA: begin a = a | m; p = set_nz(p, a); end
         OP_PHA: begin
            side.mem_write = 1'b1; side.stack_write = 1'b1; side.stack_offset = s;
            side.write_data = a; s = s - 8'd1;
         end
         OP_PHP: begin
            side.mem_write = 1'b1; side.stack_write = 1'b1; side.stack_offset = s;
            side.write_data = p; side.write_data[FLAG_B] = 1'b1;
            side.write_data[FLAG_U] = 1'b1; s = s - 8'd1;
         end
         OP_PLA: begin s = s + 8'd1; a = pulled_byte; p = set_nz(p, a); end
         OP_PLP: begin
            s = s + 8'd1; p = pulled_byte; p[FLAG_U] = 1'b1; p[FLAG_B] = 1'b0;
         end
         OP_RLA: begin
            r = {m[6:0], p[FLAG_C]}; p[FLAG_C] = m[7];
            side.mem_write = 1'b1; side.write_data = r;
            a = a & r; p = set_nz(p, a);
         end
         OP_ROL: begin
            r = {m[6:0], p[FLAG_C]}; p[FLAG_C] = m[7]; shift_kind = 1'b1;
         end
         OP_ROR: begin
            r = {p[FLAG_C], m[7:1]}; p[FLAG_C] = m[0]; shift_kind = 1'b1;
         end
         OP_RRA: begin
            r = {p[FLAG_C], m[7:1]}; p[FLAG_C] = m[0];
            side.mem_write = 1'b1; side.write_data = r;
            ac = add_c(p, a, r); p = ac[15:8]; a = ac[7:0];
         end
         OP_SAX: begin side.mem_write = 1'b1; side.write_data = a & x; end
         OP_SBC: begin ac = add_c(p, a, ~m); p = ac[15:8]; a = ac[7:0]; end
         OP_SEC: p[FLAG_C] = 1'b1;
         OP_SED: p[FLAG_D] = 1'b1;
         OP_SEI: p[FLAG_I] = 1'b1;
         OP_SHX: begin side.mem_write = 1'b1; side.write_data = x & hi1; end
         OP_SHY: begin side.mem_write = 1'b1; side.write_data = y & hi1; end
         OP_SLO: begin
            r = {m[6:0], 1'b0}; p[FLAG_C] = m[7];
            side.mem_write = 1'b1; side.write_data = r;
            a = a | r; p = set_nz(p, a);
         end
         OP_SRE: begin
            p[FLAG_C] = m[0]; r = {1'b0, m[7:1]};
            side.mem_write = 1'b1; side.write_data = r;
            a = a ^ r; p = set_nz(p, a);
         end
         OP_STA: begin side.mem_write = 1'b1; side.write_data = a; end
         OP_STX: begin side.mem_write = 1'b1; side.write_data = x; end
         OP_STY: begin side.mem_write = 1'b1; side.write_data = y; end
         OP_TAS: begin s = a & x; side.mem_write = 1'b1; side.write_data = s & hi1; end
         OP_TAX: begin x = a; p = set_nz(p, x); end
         OP_TAY: begin y = a; p = set_nz(p, y); end
         OP_TSX: begin x = s; p = set_nz(p, x); end
         OP_TXA: begin a = x; p = set_nz(p, a); end
         OP_TXS: s = x;
         OP_TYA: begin a = y; p = set_nz(p, a); end
         OP_XAA: begin a = x & m; p = set_nz(p, a); end
         default: ;
      endcase
      // Read-modify-write shifts target A in accumulator mode, memory otherwise.
      if (shift_kind) begin
         p = set_nz(p, r);
         if (accumulator_mode) begin
            a = r;
         end else begin
            side.mem_write  = 1'b1;
            side.write_data = r;
         end
      end
      regs_nxt.acc    = a;
      regs_nxt.idx_x  = x;
      regs_nxt.idx_y  = y;
      regs_nxt.sp     = s;
      regs_nxt.status = p;
   end

endmodule

FILE: hdl/cpu8_register_alu_execute.sv
// Top level of the 8-bit execute stage: register file, result register, handshake.
// Depends on cpu8_pkg and cpu8_exec.
//
// This block holds A, X, Y, the stack pointer and the status byte and executes one
// decoded operation per request. A request is accepted at any clock edge where the
// result register is empty or is being emptied in the same cycle, so a new request
// may follow every cycle while the result is not stalled. The execute unit works
// directly on the request ports and the current registers, and at the accepting
// edge both the register file and the result register load. The only thing that
// holds a request back is a stalled result in the single result register. Reset
// leaves A, X and Y at zero, the stack pointer at 0xFD and the status byte at
// 0x24. Arithmetic is always binary; the decimal flag is only stored.
module cpu8_register_alu_execute import cpu8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_kind,
   input  logic [7:0] req_operand,
   input  logic       req_accumulator_mode,
   input  logic [7:0] req_address_high,
   input  logic [7:0] req_pulled_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_index_x_out,
   output logic [7:0] rsp_index_y_out,
   output logic [7:0] rsp_stack_ptr_out,
   output logic [7:0] rsp_status_out,
   output logic       rsp_mem_write,
   output logic [7:0] rsp_write_data,
   output logic       rsp_stack_write,
   output logic [7:0] rsp_stack_offset,
   output logic       rsp_branch_taken,
   output logic       rsp_halt_request
);

   regs_type regs_ff, regs_in;
   side_type side_ff, side_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     req_accept;

   // The result register can take a new request when it is empty or being drained.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   cpu8_exec u_exec (
      .regs_cur         (regs_ff),
      .kind             (req_kind),
      .operand          (req_operand),
      .accumulator_mode (req_accumulator_mode),
      .address_high     (req_address_high),
      .pulled_byte      (req_pulled_byte),
      .regs_nxt         (regs_in),
      .side             (side_in)
   );

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc    <= 8'd0;
         regs_ff.idx_x  <= 8'd0;
         regs_ff.idx_y  <= 8'd0;
         regs_ff.sp     <= STACK_RESET;
         regs_ff.status <= STATUS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            regs_ff <= regs_in;
         end
      end
   end

   // The side outputs are payload only and need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         side_ff <= side_in;
      end
   end

   // The register part of a result is the register file itself after the update.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_acc_out       = regs_ff.acc;
   assign rsp_index_x_out   = regs_ff.idx_x;
   assign rsp_index_y_out   = regs_ff.idx_y;
   assign rsp_stack_ptr_out = regs_ff.sp;
   assign rsp_status_out    = regs_ff.status;
   assign rsp_mem_write     = side_ff.mem_write;
   assign rsp_write_data    = side_ff.write_data;
   assign rsp_stack_write   = side_ff.stack_write;
   assign rsp_stack_offset  = side_ff.stack_offset;
   assign rsp_branch_taken  = side_ff.branch_taken;
   assign rsp_halt_request  = side_ff.halt_request;

   // An accepted request always produces a result in the following cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   // The unused status bit is set and the break bit clear in every stored status.
   a_status_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      regs_ff.status[FLAG_U] && !regs_ff.status[FLAG_B])
      else $error("status register holds an impossible U or B value");

   // A stack write is always a memory write.
   a_stack_implies_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && side_ff.stack_write |-> side_ff.mem_write)
      else $error("stack write reported without a memory write");

   // Registers only change when a request is accepted.
   a_regs_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(regs_ff))
      else $error("register file changed without a request");

endmodule
